[design/lptf_pkg.sv]
// Shared types and constants for the lidar point transform and filter.
package lptf_pkg;

  // Pipeline depth: input register, seven divider stages, product, output.
  localparam int NUM_STAGES = 10;
  localparam int DIV_STAGES = 7;
  localparam int STEPS_PER_STAGE = 4;

  // Sweep span and frame size limits.
  localparam logic [26:0] FRAME_SPAN_NS = 27'd100000000;
  localparam int DIV_STEPS = 27;
  localparam int FRAC_STEPS = 16;
  localparam logic [16:0] MIN_FRAME_POINTS = 17'd2;
  localparam logic [16:0] MAX_POINTS = 17'd65536;

  // Config register indexes.
  localparam logic [7:0] REG_ROT_X = 8'd0;
  localparam logic [7:0] REG_ROT_Y = 8'd1;
  localparam logic [7:0] REG_ROT_Z = 8'd2;
  localparam logic [7:0] REG_TRANS = 8'd3;
  localparam logic [7:0] REG_RANGE = 8'd4;
  localparam logic [7:0] REG_BOX_XY = 8'd5;
  localparam logic [7:0] REG_BOX_Z = 8'd6;
  localparam logic [7:0] REG_TOFS = 8'd7;

  // Reset values: identity rotation, open range gate.
  localparam logic [53:0] ROT_X_RST = 54'd65536;
  localparam logic [53:0] ROT_Y_RST = 54'd17179869184;
  localparam logic [53:0] ROT_Z_RST = 54'd4503599627370496;
  localparam logic [31:0] RANGE_RST = 32'hFFFF0000;

  // One pipeline slot.
  typedef struct packed {
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [15:0]      cz;
    logic [7:0]       inten;
    logic [15:0]      idx;
    logic [16:0]      cnt;
    logic [63:0]      tsum;
    logic [8:0][33:0] prod;
    logic [2:0][20:0] q;
    logic [2:0][41:0] sq;
    logic [31:0]      min2;
    logic [31:0]      max2;
    logic             in_body;
    logic             keep;
    logic [16:0]      drem;
    logic [26:0]      dquo;
    logic [15:0]      cm1;
    logic [15:0]      frem;
    logic [15:0]      fquo;
    logic             fsat;
    logic [42:0]      tprod;
    logic [15:0]      sx;
    logic [15:0]      sy;
    logic [15:0]      sz;
    logic [63:0]      tout;
    logic [15:0]      frac;
  } pipe_t;

endpackage

[design/lidar_point_transform_filter.sv]
// Lidar point transform and filter: rotate, translate, range and self-box gate, timestamp.
//
// One point enters per clock cycle while the pipeline advances; dropped points leave no
// result and cost no output slot. The pipeline depth is set by the pipelined restoring
// divider that forms the per-point interval floor(1e8 / count): seven stages of four
// quotient bits each (the last one of three), the sweep fraction sharing the first four
// of them. The whole pipeline advances together and holds as long as a result waits at
// the output. Configuration is taken in any cycle and should only be written while the
// pipeline is empty.
module lidar_point_transform_filter (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: coord_x[15:0], coord_y[31:16], coord_z[47:32], intensity[55:48],
  // point_index[71:56], point_count[88:72], frame_time_ns[152:89], zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,
  // out_tdata: out_x[15:0], out_y[31:16], out_z[47:32], reflect[55:48],
  // point_time_ns[119:56], sweep_fraction[135:120]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import lptf_pkg::*;

  logic [53:0] rot_x_r, rot_y_r, rot_z_r;
  logic [59:0] trans_r;
  logic [31:0] range_r;
  logic [63:0] box_xy_r;
  logic [31:0] box_z_r;
  logic [63:0] tofs_r;

  pipe_t st_r [NUM_STAGES];
  pipe_t st_nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0] v_r;
  logic adv;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r  <= ROT_X_RST;
      rot_y_r  <= ROT_Y_RST;
      rot_z_r  <= ROT_Z_RST;
      trans_r  <= '0;
      range_r  <= RANGE_RST;
      box_xy_r <= '0;
      box_z_r  <= '0;
      tofs_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROT_X:  rot_x_r  <= cfg_data[53:0];
        REG_ROT_Y:  rot_y_r  <= cfg_data[53:0];
        REG_ROT_Z:  rot_z_r  <= cfg_data[53:0];
        REG_TRANS:  trans_r  <= cfg_data[59:0];
        REG_RANGE:  range_r  <= cfg_data[31:0];
        REG_BOX_XY: box_xy_r <= cfg_data;
        REG_BOX_Z:  box_z_r  <= cfg_data[31:0];
        REG_TOFS:   tofs_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless a result is waiting
  assign out_tvalid = v_r[NUM_STAGES-1] & st_r[NUM_STAGES-1].keep;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage next values
  always_comb begin
    logic [16:0] cnt;
    logic [15:0] idx;
    logic [7:0]  inten;
    logic [16:0] r;
    logic [17:0] trial;
    logic [26:0] qd;
    logic [15:0] fr;
    logic [16:0] ft;
    logic [15:0] fq;
    logic signed [17:0] c;
    logic signed [15:0] pc;
    logic signed [33:0] m;
    logic signed [35:0] acc;
    logic signed [35:0] rnd;
    logic signed [19:0] qr;
    logic signed [19:0] tr;
    logic signed [20:0] qv;
    logic signed [41:0] sqs;
    logic [43:0] d2;
    logic signed [15:0] lo, hi;
    logic [53:0] row;
    logic [2:0] in_box;
    int j;

    // Input slot
    cnt   = in_tdata[88:72];
    idx   = in_tdata[71:56];
    inten = in_tdata[55:48];
    st_nxt[0]       = '0;
    st_nxt[0].cx    = in_tdata[15:0];
    st_nxt[0].cy    = in_tdata[31:16];
    st_nxt[0].cz    = in_tdata[47:32];
    st_nxt[0].inten = inten;
    st_nxt[0].idx   = idx;
    st_nxt[0].cnt   = cnt;
    st_nxt[0].tsum  = in_tdata[152:89];
    st_nxt[0].keep  = (cnt >= MIN_FRAME_POINTS) && (cnt <= MAX_POINTS) && (inten != 8'd0);
    st_nxt[0].cm1   = 16'(cnt - 17'd1);
    st_nxt[0].frem  = idx;
    st_nxt[0].fsat  = ({1'b0, idx} + 17'd1) >= cnt;

    // Later stages
    for (int s = 1; s < NUM_STAGES; s++) begin
      st_nxt[s] = st_r[s-1];
    end

    // Restoring dividers: 1e8 / count and (index << 16) / (count - 1)
    for (int s = 1; s <= DIV_STAGES; s++) begin
      r  = st_r[s-1].drem;
      qd = st_r[s-1].dquo;
      fr = st_r[s-1].frem;
      fq = st_r[s-1].fquo;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        j = (s - 1) * STEPS_PER_STAGE + k;
        if (j < DIV_STEPS) begin
          trial = {r, FRAME_SPAN_NS[DIV_STEPS-1-j]};
          if (trial >= {1'b0, st_r[s-1].cnt}) begin
            r  = 17'(trial - {1'b0, st_r[s-1].cnt});
            qd = {qd[25:0], 1'b1};
          end else begin
            r  = trial[16:0];
            qd = {qd[25:0], 1'b0};
          end
        end
        if (j < FRAC_STEPS) begin
          ft = {fr, 1'b0};
          if (ft >= {1'b0, st_r[s-1].cm1}) begin
            fr = 16'(ft - {1'b0, st_r[s-1].cm1});
            fq = {fq[14:0], 1'b1};
          end else begin
            fr = ft[15:0];
            fq = {fq[14:0], 1'b0};
          end
        end
      end
      st_nxt[s].drem = r;
      st_nxt[s].dquo = qd;
      st_nxt[s].frem = fr;
      st_nxt[s].fquo = fq;
    end

    // Stage 1: nine coefficient products, timestamp base
    st_nxt[1].tsum = st_r[0].tsum + tofs_r;
    for (int rw = 0; rw < 3; rw++) begin
      row = (rw == 0) ? rot_x_r : ((rw == 1) ? rot_y_r : rot_z_r);
      for (int k = 0; k < 3; k++) begin
        c  = row[18*k +: 18];
        pc = (k == 0) ? st_r[0].cx : ((k == 1) ? st_r[0].cy : st_r[0].cz);
        m  = 34'(c) * 34'(pc);
        st_nxt[1].prod[rw*3+k] = m;
      end
    end

    // Stage 2: row sums, round to mm, translate
    for (int rw = 0; rw < 3; rw++) begin
      acc = 36'($signed(st_r[1].prod[rw*3]));
      acc = acc + 36'($signed(st_r[1].prod[rw*3+1]));
      acc = acc + 36'($signed(st_r[1].prod[rw*3+2]));
      rnd = acc + 36'sd32768;
      qr  = rnd[35:16];
      tr  = trans_r[20*rw +: 20];
      qv  = 21'(qr) + 21'(tr);
      st_nxt[2].q[rw] = qv;
    end

    // Stage 3: squares, self-box test and squared range limits
    for (int k = 0; k < 3; k++) begin
      qv  = st_r[2].q[k];
      sqs = 42'(qv) * 42'(qv);
      st_nxt[3].sq[k] = sqs;
      lo = (k == 2) ? box_z_r[15:0]  : box_xy_r[32*k +: 16];
      hi = (k == 2) ? box_z_r[31:16] : box_xy_r[32*k+16 +: 16];
      in_box[k] = (qv >= lo) && (qv <= hi);
    end
    st_nxt[3].in_body = &in_box;
    st_nxt[3].min2 = 32'(range_r[15:0]) * 32'(range_r[15:0]);
    st_nxt[3].max2 = 32'(range_r[31:16]) * 32'(range_r[31:16]);

    // Stage 4: self-box and range gate
    d2 = 44'(st_r[3].sq[0]) + 44'(st_r[3].sq[1]) + 44'(st_r[3].sq[2]);
    st_nxt[4].keep = st_r[3].keep && !st_r[3].in_body &&
                     !(d2 < 44'(st_r[3].min2) || d2 > 44'(st_r[3].max2));

    // Stage 8: index times interval
    st_nxt[8].tprod = 43'(st_r[7].idx) * 43'(st_r[7].dquo);

    // Stage 9: timestamp, saturation, fraction
    st_nxt[9].tout = st_r[8].tsum + 64'(st_r[8].tprod);
    st_nxt[9].frac = st_r[8].fsat ? 16'hFFFF : st_r[8].fquo;
    for (int k = 0; k < 3; k++) begin
      qv = st_r[8].q[k];
      if (qv > 21'sd32767) begin
        lo = 16'sh7FFF;
      end else if (qv < -21'sd32768) begin
        lo = 16'sh8000;
      end else begin
        lo = qv[15:0];
      end
      if (k == 0) begin
        st_nxt[9].sx = lo;
      end else if (k == 1) begin
        st_nxt[9].sy = lo;
      end else begin
        st_nxt[9].sz = lo;
      end
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NUM_STAGES-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_tdata = {st_r[NUM_STAGES-1].frac, st_r[NUM_STAGES-1].tout,
                      st_r[NUM_STAGES-1].inten, st_r[NUM_STAGES-1].sz,
                      st_r[NUM_STAGES-1].sy, st_r[NUM_STAGES-1].sx};

`ifndef SYNTHESIS
  // A waiting result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("input taken during stall");

  // Valid bits hold while stalled
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r)) else $error("pipeline moved during stall");

  // Results only for frames of at least two points and nonzero intensity
  a_keep_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_r[NUM_STAGES-1].cnt >= MIN_FRAME_POINTS) &&
                   (st_r[NUM_STAGES-1].inten != 8'd0)) else $error("bad frame kept");

  // Interval remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STAGES] && st_r[DIV_STAGES].keep |->
      st_r[DIV_STAGES].drem < st_r[DIV_STAGES].cnt) else $error("divider remainder");
`endif

endmodule
